FILE: sv/hfa_pkg.sv
// shared types and constants of the hole fit allocator
// no dependencies
`timescale 1ns / 1ps

package hfa_pkg;

    localparam int DEF_MAX_HOLES = 64;
    localparam int DEF_SIZE_BITS = 16;

    localparam int AMOUNT_W = 16;
    localparam int SLOT_W   = 6;
    localparam int INDEX_W  = 6;
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 7;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd0;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd1;
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_REQ  = 1'b1;

    localparam logic REG_FIT_MODE   = 1'b0;
    localparam logic REG_HOLE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

FILE: sv/hfa_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module hfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/hole_fit_allocator.sv
// hole fit allocator top level: config registers, scan sequencer, result register
// depends on hfa_pkg and hfa_ram
//
// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_stall     i_func, i_slot, i_amount
// out       output     o_out_valid / i_out_stall   o_granted, o_hole_index
// config    input      psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// a load transfer writes the hole ram directly
// a request goes through the transfer, one ram read per hole slot up to
// min(hole_count, MAX_HOLES), the check of the last read data and the write back
// the write back waits while the result register still holds an untaken result
// reset is synchronous and clears the sequencer, config and result valid; ram is not cleared
`timescale 1ns / 1ps

module hole_fit_allocator
    import hfa_pkg::*;
#(
    parameter int MAX_HOLES = DEF_MAX_HOLES,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_func,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [AMOUNT_W-1:0] i_amount,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_granted,
    output logic [INDEX_W-1:0]  o_hole_index,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int IDX_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int CNT_W = $clog2(MAX_HOLES + 1);
    localparam int LIM_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SLW   = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    t_state r_state, n_state;

    logic [MODE_W-1:0]    r_fit_mode;
    logic [COUNT_W-1:0]   r_hole_count;

    logic [CNT_W-1:0]     r_addr, n_addr;
    logic                 r_pend, n_pend;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    logic [SIZE_BITS-1:0] r_need, n_need;
    logic [SIZE_BITS-1:0] r_best, n_best;
    logic [IDX_W-1:0]     r_at, n_at;
    logic                 r_found, n_found;

    logic                 r_out_valid, n_out_valid;
    logic                 r_granted, n_granted;
    logic [INDEX_W-1:0]   r_hole_index, n_hole_index;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic [SIZE_BITS-1:0] ram_rdata;

    logic                 in_xfer;
    logic                 out_free;
    logic                 cfg_wr;
    logic [LIM_W-1:0]     hc_ext;
    logic [LIM_W-1:0]     lim;
    logic                 issue;
    logic [SLW-1:0]       slot_ext;
    logic [SLW-1:0]       at_ext;
    logic                 take;
    logic [SIZE_BITS-1:0] need_in;

    hfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_HOLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode   <= FIT_BEST;
            r_hole_count <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FIT_MODE:   r_fit_mode   <= pwdata[MODE_W-1:0];
                REG_HOLE_COUNT: r_hole_count <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FIT_MODE:   prdata = PDATA_W'(r_fit_mode);
            REG_HOLE_COUNT: prdata = PDATA_W'(r_hole_count);
            default:        prdata = '0;
        endcase
    end

    // handshakes
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid & ~o_in_stall;
    assign out_free    = ~r_out_valid | ~i_out_stall;

    assign need_in  = SIZE_BITS'(i_amount);
    assign slot_ext = SLW'(i_slot);
    assign at_ext   = SLW'(r_at);

    // scan limit
    assign hc_ext = LIM_W'(r_hole_count);
    assign lim    = (hc_ext > LIM_W'(MAX_HOLES)) ? LIM_W'(MAX_HOLES) : hc_ext;
    assign issue  = LIM_W'(r_addr) < lim;

    // hole selection on returned read data
    always_comb begin
        take = 1'b0;
        if (r_pend && ram_rdata >= r_need) begin
            case (r_fit_mode)
                FIT_BEST:  take = ~r_found | (ram_rdata <= r_best);
                FIT_WORST: take = ram_rdata > r_best;
                FIT_FIRST: take = ~r_found;
                default:   take = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_rd_idx     <= n_rd_idx;
        r_need       <= n_need;
        r_best       <= n_best;
        r_at         <= n_at;
        r_found      <= n_found;
        r_granted    <= n_granted;
        r_hole_index <= n_hole_index;
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_pend       = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_need       = r_need;
        n_best       = r_best;
        n_at         = r_at;
        n_found      = r_found;
        n_out_valid  = r_out_valid & i_out_stall;
        n_granted    = r_granted;
        n_hole_index = r_hole_index;
        ram_we       = 1'b0;
        ram_waddr    = r_at;
        ram_wdata    = r_best - r_need;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_func == FUNC_REQ) begin
                        n_state = ST_SCAN;
                        n_addr  = '0;
                        n_need  = need_in;
                        n_best  = '0;
                        n_at    = '0;
                        n_found = 1'b0;
                    end else if (slot_ext < SLW'(MAX_HOLES)) begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_ext[IDX_W-1:0];
                        ram_wdata = need_in;
                    end
                end
            end
            ST_SCAN: begin
                if (take) begin
                    n_found = 1'b1;
                    n_best  = ram_rdata;
                    n_at    = r_rd_idx;
                end
                if (issue) begin
                    n_pend   = 1'b1;
                    n_rd_idx = r_addr[IDX_W-1:0];
                    n_addr   = r_addr + 1'b1;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    ram_we       = r_found;
                    n_out_valid  = 1'b1;
                    n_granted    = r_found;
                    n_hole_index = r_found ? at_ext[INDEX_W-1:0] : '0;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_granted    = r_granted;
    assign o_hole_index = r_hole_index;

endmodule

FILE: sv/hfa_checker.sv
// port level checks of the hole fit allocator, bound to the top level
// depends on hfa_pkg and hole_fit_allocator
`timescale 1ns / 1ps

module hfa_checker
    import hfa_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_func,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_granted,
    input logic [INDEX_W-1:0] o_hole_index,
    input logic               pready
);

    // stalled result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_granted) && $stable(o_hole_index))
        else $error("result changed while stalled");

    // a refused request reports index zero
    a_refuse_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_granted |-> o_hole_index == '0)
        else $error("refused request with nonzero index");

    // a request transfer starts a scan that blocks the input
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_func == FUNC_REQ |=> o_in_stall)
        else $error("input open right after request");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind hole_fit_allocator hfa_checker u_hfa_checker (.*);

FILE: test/hole_fit_allocator_tb.sv
// self-checking testbench for hole_fit_allocator: directed and random transfers
// under three idle patterns, checked against an in-bench prediction of the hole table
// depends on hfa_pkg and the hole_fit_allocator rtl
`timescale 1ns / 1ps

module hole_fit_allocator_tb;
    import hfa_pkg::*;

    localparam logic [MODE_W-1:0] FIT_NONE = 2'd3;
    localparam int SETTLE_CYCLES = DEF_MAX_HOLES + 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int SEGMENTS      = 8;
    localparam int SEG_ITEMS     = 66;

    typedef struct packed {
        logic               granted;
        logic [INDEX_W-1:0] hole_index;
    } t_grant;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_func = FUNC_LOAD;
    logic [SLOT_W-1:0]   i_slot = '0;
    logic [AMOUNT_W-1:0] i_amount = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_granted;
    logic [INDEX_W-1:0]  o_hole_index;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // predicted block state
    logic [AMOUNT_W-1:0] hole_size [DEF_MAX_HOLES];
    logic [MODE_W-1:0]   cur_mode = FIT_BEST;
    logic [COUNT_W-1:0]  cur_count = '0;
    t_grant              grant_q [$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int err_cnt = 0;
    int idle_cycles = 0;
    int n_loads = 0;
    int n_reqs = 0;
    int n_grants = 0;
    int n_refusals = 0;

    hole_fit_allocator u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_slot       (i_slot),
        .i_amount     (i_amount),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_granted    (o_granted),
        .o_hole_index (o_hole_index),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    task automatic report_mismatch(input string what, input int unsigned exp_v,
                                   input int unsigned got_v);
        $display("mismatch: %s expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
        err_cnt++;
    endtask

    // places one request into the predicted table, as the block would
    task automatic place_request(input logic [AMOUNT_W-1:0] need, output logic ok,
                                 output logic [INDEX_W-1:0] at);
        int lim;
        logic found;
        logic [AMOUNT_W-1:0] pick;
        found = 1'b0;
        pick = '0;
        at = '0;
        lim = (cur_count > DEF_MAX_HOLES) ? DEF_MAX_HOLES : cur_count;
        for (int i = 0; i < lim; i++) begin
            case (cur_mode)
                FIT_BEST: begin
                    if (hole_size[i] >= need && (!found || hole_size[i] <= pick)) begin
                        found = 1'b1;
                        pick = hole_size[i];
                        at = INDEX_W'(i);
                    end
                end
                FIT_WORST: begin
                    if (hole_size[i] >= need && hole_size[i] > pick) begin
                        found = 1'b1;
                        pick = hole_size[i];
                        at = INDEX_W'(i);
                    end
                end
                FIT_FIRST: begin
                    if (!found && hole_size[i] >= need) begin
                        found = 1'b1;
                        at = INDEX_W'(i);
                    end
                end
                default: ;
            endcase
        end
        if (found) hole_size[at] = hole_size[at] - need;
        else at = '0;
        ok = found;
    endtask

    task automatic send_item(input logic func, input logic [SLOT_W-1:0] slot,
                             input logic [AMOUNT_W-1:0] amount);
        logic ok;
        logic [INDEX_W-1:0] at;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= func;
        i_slot <= slot;
        i_amount <= amount;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (func == FUNC_LOAD) begin
            hole_size[slot] = amount;
            n_loads++;
        end else begin
            place_request(amount, ok, at);
            grant_q.push_back('{granted: ok, hole_index: at});
            n_reqs++;
        end
    endtask

    // sender holds off until every pending request has been answered
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input logic [PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        if (sel == REG_FIT_MODE) cur_mode = value[MODE_W-1:0];
        else cur_count = value[COUNT_W-1:0];
    endtask

    always @(posedge i_clk) begin
        t_grant exp_g;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (grant_q.size() == 0) begin
                report_mismatch("result with no request pending", 0, 1);
            end else begin
                exp_g = grant_q.pop_front();
                if (o_granted !== exp_g.granted)
                    report_mismatch("granted", exp_g.granted, o_granted);
                if (o_hole_index !== exp_g.hole_index)
                    report_mismatch("hole_index", exp_g.hole_index, o_hole_index);
                if (exp_g.granted) n_grants++;
                else n_refusals++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)
            || (psel && penable && pwrite && pready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        write_reg(REG_FIT_MODE, PDATA_W'(FIT_BEST));
        write_reg(REG_HOLE_COUNT, 0);
        // zero hole count refuses everything
        send_item(FUNC_REQ, 6'd0, 16'd5);
        send_item(FUNC_LOAD, 6'd0, 16'd10);
        send_item(FUNC_LOAD, 6'd1, 16'd0);
        send_item(FUNC_LOAD, 6'd2, 16'd10);
        send_item(FUNC_LOAD, 6'd3, 16'hFFFF);
        // load beyond hole count
        send_item(FUNC_LOAD, 6'h3F, 16'd7);
        drain_results();
        write_reg(REG_HOLE_COUNT, 4);
        // best fit tie goes high, zero request fits a zero hole
        send_item(FUNC_REQ, 6'h3F, 16'd10);
        send_item(FUNC_REQ, 6'd0, 16'd0);
        send_item(FUNC_REQ, 6'd0, 16'hFFFF);
        send_item(FUNC_REQ, 6'd0, 16'd1);
        drain_results();
        write_reg(REG_FIT_MODE, PDATA_W'(FIT_WORST));
        for (int i = 0; i < 4; i++) send_item(FUNC_LOAD, SLOT_W'(i), 16'd0);
        // worst fit skips zero holes
        send_item(FUNC_REQ, 6'd0, 16'd0);
        send_item(FUNC_LOAD, 6'd1, 16'd20);
        send_item(FUNC_LOAD, 6'd2, 16'd20);
        send_item(FUNC_REQ, 6'd0, 16'd3);
        drain_results();
        write_reg(REG_FIT_MODE, PDATA_W'(FIT_FIRST));
        send_item(FUNC_REQ, 6'd0, 16'd20);
        send_item(FUNC_REQ, 6'h2A, 16'h8000);
        drain_results();
        write_reg(REG_FIT_MODE, PDATA_W'(FIT_NONE));
        send_item(FUNC_REQ, 6'h15, 16'd1);
        drain_results();
    endtask

    task automatic test_fill_table();
        for (int i = 0; i < DEF_MAX_HOLES; i++)
            send_item(FUNC_LOAD, SLOT_W'(i),
                      ($urandom_range(3) == 0) ? 16'hFFFF : AMOUNT_W'($urandom_range(65535)));
        drain_results();
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int phase);
        int lim;
        int k;
        logic [SLOT_W-1:0] slot;
        logic [AMOUNT_W-1:0] amount;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int s = 0; s < SEGMENTS; s++) begin
            drain_results();
            write_reg(REG_FIT_MODE, (s + phase) % 4);
            case (s)
                0: write_reg(REG_HOLE_COUNT, 127);
                1: write_reg(REG_HOLE_COUNT, DEF_MAX_HOLES);
                2: write_reg(REG_HOLE_COUNT, 0);
                3: write_reg(REG_HOLE_COUNT, 1);
                default: write_reg(REG_HOLE_COUNT, $urandom_range(1) ? $urandom_range(2, 12)
                                                                     : $urandom_range(13, 127));
            endcase
            lim = (cur_count > DEF_MAX_HOLES) ? DEF_MAX_HOLES : cur_count;
            for (int n = 0; n < SEG_ITEMS; n++) begin
                if (n == SEG_ITEMS / 2) drain_results();
                k = $urandom_range(9);
                if ($urandom_range(99) < 35) begin
                    slot = SLOT_W'(($urandom_range(3) == 0 || lim == 0) ? $urandom_range(63)
                                                                        : $urandom_range(lim - 1));
                    case (k)
                        0: amount = '0;
                        1: amount = 16'hFFFF;
                        2: amount = hole_size[$urandom_range(63)];
                        3, 4, 5: amount = AMOUNT_W'($urandom_range(1, 64));
                        default: amount = AMOUNT_W'($urandom_range(65535));
                    endcase
                    send_item(FUNC_LOAD, slot, amount);
                end else begin
                    case (k)
                        0: amount = '0;
                        1: amount = 16'hFFFF;
                        2: amount = hole_size[(lim == 0) ? 0 : $urandom_range(lim - 1)];
                        3, 4, 5, 6: amount = AMOUNT_W'($urandom_range(1, 40));
                        7: amount = AMOUNT_W'($urandom_range(65535));
                        default: amount = AMOUNT_W'($urandom_range(1, 2000));
                    endcase
                    send_item(FUNC_REQ, SLOT_W'($urandom_range(63)), amount);
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_table();
        test_random_traffic(30, 87, 0);
        test_random_traffic(87, 30, 1);
        test_random_traffic(0, 0, 2);
        drain_results();
        if (grant_q.size() != 0) report_mismatch("requests left unanswered", 0, grant_q.size());
        $display("covered %0d hole loads and %0d requests over all fit modes and hole counts",
                 n_loads, n_reqs);
        $display("answers: %0d grants, %0d refusals, %0d mismatches",
                 n_grants, n_refusals, err_cnt);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/hfa_pkg.sv
sv/hfa_ram.sv
sv/hole_fit_allocator.sv
sv/hfa_checker.sv
test/hole_fit_allocator_tb.sv
